// ===== rtl/triv_pkg.sv =====
package triv_pkg;

    localparam int LEN_A = 93;
    localparam int LEN_B = 84;
    localparam int LEN_C = 111;

    localparam int DATA_W = 32;
    localparam int KEY_HIGH_W = 16;
    localparam int KEY_LOW_W = 64;
    localparam int KEY_BITS = KEY_HIGH_W + KEY_LOW_W;
    localparam int CFG_W = 64;
    localparam int CFG_INDEX_W = 2;

    localparam int DEFAULT_WORD_BITS = 32;

    localparam int WARM_ROUNDS = 4 * 288;
    localparam int WARM_BITS_PER_STEP = 32;
    localparam int WARM_STEPS = WARM_ROUNDS / WARM_BITS_PER_STEP;
    localparam int WARM_CNT_W = $clog2(WARM_STEPS + 1);

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IV_LOW = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IV_HIGH = 2'd3;

    // Bit n of the published state numbering sits at index n-1 of its register.
    typedef struct packed {
        logic [LEN_A-1:0] a;
        logic [LEN_B-1:0] b;
        logic [LEN_C-1:0] c;
    } triv_state_t;

endpackage

// ===== rtl/triv_rounds.sv =====
module triv_rounds #(
    parameter int ROUNDS = triv_pkg::DEFAULT_WORD_BITS
) (
    input  triv_pkg::triv_state_t state_in,
    output triv_pkg::triv_state_t state_out,
    output logic [ROUNDS-1:0]     keystream
);

    // Each new bit is not tapped again for at least 66 rounds, so the unrolled
    // rounds stay a few XOR levels deep.
    always_comb
    begin
        logic [triv_pkg::LEN_A-1:0] a;
        logic [triv_pkg::LEN_B-1:0] b;
        logic [triv_pkg::LEN_C-1:0] c;
        logic t1;
        logic t2;
        logic t3;
        a = state_in.a;
        b = state_in.b;
        c = state_in.c;
        keystream = '0;
        for (int i = 0; i < ROUNDS; i++)
        begin
            t1 = a[65] ^ a[92];
            t2 = b[68] ^ b[83];
            t3 = c[65] ^ c[110];
            keystream[ROUNDS-1-i] = t1 ^ t2 ^ t3;
            t1 = t1 ^ (a[90] & a[91]) ^ b[77];
            t2 = t2 ^ (b[81] & b[82]) ^ c[86];
            t3 = t3 ^ (c[108] & c[109]) ^ a[68];
            a = {a[triv_pkg::LEN_A-2:0], t3};
            b = {b[triv_pkg::LEN_B-2:0], t1};
            c = {c[triv_pkg::LEN_C-2:0], t2};
        end
        state_out.a = a;
        state_out.b = b;
        state_out.c = c;
    end

endmodule

// ===== rtl/trivium_stream_cipher_top.sv =====
// Trivium stream cipher with an 80-bit key and an 80-bit IV.
// Key and IV are written through the configuration port (index 0 key_low,
// 1 key_high, 2 iv_low, 3 iv_high) and take effect at the next init item.
// Input items arrive on the s_ channel: tuser selects init (0) or data (1),
// tdata carries the data word and tlast marks the last word of a message.
// An init item loads key and IV into the 288-bit state and then runs the
// 1152 warm-up rounds, 32 rounds per cycle, during which s_tready is low;
// it produces no result. The next item can be accepted once the warm-up is done.
// A data item produces one result on the m_ channel in the cycle after it is
// accepted: the word XOR WORD_BITS keystream bits, first bit at the MSB when
// WORD_BITS is 32, with tlast copied. Data items are taken every cycle, since
// all rounds of a word are done by one unrolled round block between the state
// and the output register. When the receiver stalls, the result holds in the
// output register and s_tready drops until the result is taken.
// Reset clears the state, the key and IV registers and the output valid;
// data before any init sees an all-zero keystream.
module trivium_stream_cipher_top #(
    parameter int WORD_BITS = triv_pkg::DEFAULT_WORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [triv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [triv_pkg::CFG_W-1:0]          cfg_data,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [triv_pkg::DATA_W-1:0]         s_tdata,   // [31:0] data_word
    input  logic                                s_tuser,   // [0] command
    input  logic                                s_tlast,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [triv_pkg::DATA_W-1:0]         m_tdata,   // [31:0] cipher_word
    output logic                                m_tlast
);

    logic [triv_pkg::KEY_LOW_W-1:0]  key_low_reg;
    logic [triv_pkg::KEY_HIGH_W-1:0] key_high_reg;
    logic [triv_pkg::KEY_LOW_W-1:0]  iv_low_reg;
    logic [triv_pkg::KEY_HIGH_W-1:0] iv_high_reg;

    triv_pkg::triv_state_t           state_reg;
    triv_pkg::triv_state_t           state_next;
    triv_pkg::triv_state_t           state_loaded;
    triv_pkg::triv_state_t           state_data;
    triv_pkg::triv_state_t           state_warm;

    logic [triv_pkg::WARM_CNT_W-1:0] warm_cnt_reg;
    logic [triv_pkg::WARM_CNT_W-1:0] warm_cnt_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [triv_pkg::DATA_W-1:0]     out_data_reg;
    logic                            out_last_reg;

    logic [WORD_BITS-1:0]            ks_data;
    logic [triv_pkg::WARM_BITS_PER_STEP-1:0] ks_warm;
    logic [triv_pkg::DATA_W-1:0]     ks_word;

    logic                            out_free;
    logic                            accept;
    logic                            accept_init;
    logic                            accept_data;

    triv_rounds #(
        .ROUNDS(WORD_BITS)
    ) u_data_rounds (
        .state_in (state_reg),
        .state_out(state_data),
        .keystream(ks_data)
    );

    triv_rounds #(
        .ROUNDS(triv_pkg::WARM_BITS_PER_STEP)
    ) u_warm_rounds (
        .state_in (state_reg),
        .state_out(state_warm),
        .keystream(ks_warm)
    );

    generate
        if (WORD_BITS >= triv_pkg::DATA_W)
        begin : g_ks_trim
            assign ks_word = ks_data[triv_pkg::DATA_W-1:0];
        end
        else
        begin : g_ks_pad
            assign ks_word = {{(triv_pkg::DATA_W - WORD_BITS){1'b0}}, ks_data};
        end
    endgenerate

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (warm_cnt_reg == '0) && out_free;
    assign accept      = s_tvalid && s_tready;
    assign accept_init = accept && (s_tuser == triv_pkg::CMD_INIT);
    assign accept_data = accept && (s_tuser == triv_pkg::CMD_DATA);

    // Key bit K1 and IV bit IV1 go to state bits 1 and 94; state bits 286..288 are set.
    always_comb
    begin
        state_loaded = '0;
        for (int j = 0; j < triv_pkg::KEY_HIGH_W; j++)
        begin
            state_loaded.a[j] = key_high_reg[triv_pkg::KEY_HIGH_W-1-j];
            state_loaded.b[j] = iv_high_reg[triv_pkg::KEY_HIGH_W-1-j];
        end
        for (int j = triv_pkg::KEY_HIGH_W; j < triv_pkg::KEY_BITS; j++)
        begin
            state_loaded.a[j] = key_low_reg[triv_pkg::KEY_BITS-1-j];
            state_loaded.b[j] = iv_low_reg[triv_pkg::KEY_BITS-1-j];
        end
        state_loaded.c[triv_pkg::LEN_C-1 -: 3] = 3'b111;
    end

    always_comb
    begin
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        if (accept_init)
        begin
            state_next    = state_loaded;
            warm_cnt_next = triv_pkg::WARM_CNT_W'(triv_pkg::WARM_STEPS);
        end
        else if (warm_cnt_reg != '0)
        begin
            state_next    = state_warm;
            warm_cnt_next = warm_cnt_reg - 1'b1;
        end
        else if (accept_data)
        begin
            state_next = state_data;
        end
    end

    always_comb
    begin
        if (accept_data)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            iv_low_reg    <= '0;
            iv_high_reg   <= '0;
            state_reg     <= '0;
            warm_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    triv_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    triv_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data[triv_pkg::KEY_HIGH_W-1:0];
                    triv_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                    triv_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data[triv_pkg::KEY_HIGH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            warm_cnt_reg  <= warm_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_data)
        begin
            out_data_reg <= s_tdata ^ ks_word;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/triv_checker.sv =====
module triv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [triv_pkg::DATA_W-1:0]      m_tdata,
    input logic                             m_tlast
);

    // A stalled result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed or vanished");

    // A data item gives its result in the next cycle with its marker copied.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == triv_pkg::CMD_DATA)
        |=> m_tvalid && (m_tlast == $past(s_tlast)))
        else $error("data item gave no result or lost its marker");

    // An init item gives no result and starts the warm-up.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == triv_pkg::CMD_INIT) |=> !m_tvalid && !s_tready)
        else $error("init item gave a result or did not start the warm-up");

    // Input is taken only when the output register can hold a new result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while a result is stalled");

endmodule

bind trivium_stream_cipher_top triv_checker u_triv_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
